/* hw/rtl/tzc_pkg.sv */
package tzc_pkg;

	// Fixed field widths.
	localparam int ACCEL_W = 16;
	localparam int ANGLE_W = 15;
	localparam int THR_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// Defaults for the top-level parameters.
	localparam int CORDIC_ITERATIONS_DEF   = 16;
	localparam int ANGLE_FRACTION_BITS_DEF = 7;

	// Arithmetic widths.
	localparam int SUM_W    = 32;	// sum of two squares
	localparam int ROOT_W   = 24;	// floor sqrt of sum * 2^16
	localparam int SQ_STEPS = ROOT_W;	// one result bit per stage
	localparam int XY_W     = 28;	// CORDIC x and y
	localparam int Z_W      = 26;	// angle accumulator, 16 fraction bits
	localparam int ACC_FRAC = 16;
	localparam int TAB_LEN  = 24;

	// Zone codes.
	typedef enum logic [1:0] {
		ZONE_LEVEL = 2'd0,
		ZONE_HIGH  = 2'd1,
		ZONE_LOW   = 2'd2
	} zone_t;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_UP    = 2'd0,
		REG_PITCH_DOWN  = 2'd1,
		REG_ROLL_RIGHT  = 2'd2,
		REG_ROLL_LEFT   = 2'd3
	} reg_idx_t;

	// Threshold set handed to the classifier.
	typedef struct packed {
		logic signed [THR_W-1:0] pitch_up;
		logic signed [THR_W-1:0] pitch_down;
		logic signed [THR_W-1:0] roll_right;
		logic signed [THR_W-1:0] roll_left;
	} thr_t;

	// atan(2^-i) in degrees with 16 fraction bits.
	function automatic logic signed [Z_W-1:0] atan_entry(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466945;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/tzc_square.sv */
module tzc_square import tzc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [ACCEL_W-1:0] ax,
	input  logic signed [ACCEL_W-1:0] ay,
	input  logic signed [ACCEL_W-1:0] az,
	output logic                      out_valid,
	output logic [SUM_W-1:0]          pitch_sum,
	output logic [SUM_W-1:0]          roll_sum,
	output logic signed [ACCEL_W-1:0] pitch_num,
	output logic signed [ACCEL_W-1:0] roll_num,
	output logic                      zero
);

	logic                      v_s1, v_s2;
	logic signed [2*ACCEL_W-1:0] xx_s1, yy_s1, zz_s1;
	logic signed [ACCEL_W-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic                      zero_s1, zero_s2;
	logic [SUM_W-1:0]          psum_s2, rsum_s2;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage one squares the axes, stage two adds pairs of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1   <= ax * ax;
			yy_s1   <= ay * ay;
			zz_s1   <= az * az;
			ax_s1   <= ax;
			ay_s1   <= ay;
			zero_s1 <= (ax == '0) && (ay == '0) && (az == '0);
			psum_s2 <= SUM_W'(yy_s1) + SUM_W'(zz_s1);
			rsum_s2 <= SUM_W'(xx_s1) + SUM_W'(zz_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			zero_s2 <= zero_s1;
		end
	end

	assign out_valid = v_s2;
	assign pitch_sum = psum_s2;
	assign roll_sum  = rsum_s2;
	assign pitch_num = ax_s2;
	assign roll_num  = ay_s2;
	assign zero      = zero_s2;

endmodule

/* hw/rtl/tzc_isqrt.sv */
module tzc_isqrt import tzc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [SUM_W-1:0]          in_sum,
	input  logic signed [ACCEL_W-1:0] in_num,
	input  logic                      in_zero,
	output logic                      out_valid,
	output logic [ROOT_W-1:0]         out_root,
	output logic signed [ACCEL_W-1:0] out_num,
	output logic                      out_zero
);

	localparam int REM_W = ROOT_W + 1;

	logic                      v_s    [0:SQ_STEPS];
	logic [REM_W-1:0]          rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0]         root_s [0:SQ_STEPS];
	logic [SUM_W-1:0]          sum_s  [0:SQ_STEPS];
	logic signed [ACCEL_W-1:0] num_s  [0:SQ_STEPS];
	logic                      zero_s [0:SQ_STEPS];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sum_s[0]  = in_sum;
	assign num_s[0]  = in_num;
	assign zero_s[0] = in_zero;

	// One root bit per stage, most significant first; the radicand is sum * 2^16.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam int I = SQ_STEPS - 1 - k;
		logic [1:0]       pair;
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             take;

		if (I >= 8) begin : g_bits
			assign pair = sum_s[k][2*I-15 -: 2];
		end else begin : g_low
			assign pair = 2'b00;
		end

		always_comb begin
			cur   = {rem_s[k], pair};
			trial = (REM_W+2)'({root_s[k], 2'b01});
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], take};
				sum_s[k+1]  <= sum_s[k];
				num_s[k+1]  <= num_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign out_root  = root_s[SQ_STEPS];
	assign out_num   = num_s[SQ_STEPS];
	assign out_zero  = zero_s[SQ_STEPS];

endmodule

/* hw/rtl/tzc_cordic.sv */
module tzc_cordic import tzc_pkg::*; #(
	parameter int ITER = CORDIC_ITERATIONS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [ROOT_W-1:0]         in_root,
	input  logic signed [ACCEL_W-1:0] in_num,
	input  logic                      in_zero,
	output logic                      out_valid,
	output logic signed [Z_W-1:0]     out_z,
	output logic                      out_zero
);

	logic                  v_s    [0:ITER];
	logic signed [XY_W-1:0] x_s   [0:ITER];
	logic signed [XY_W-1:0] y_s   [0:ITER];
	logic signed [Z_W-1:0] z_s    [0:ITER];
	logic                  zero_s [0:ITER];

	assign v_s[0]    = in_valid;
	assign x_s[0]    = XY_W'(in_root);
	assign y_s[0]    = XY_W'(in_num) <<< 8;
	assign z_s[0]    = '0;
	assign zero_s[0] = in_zero;

	// Vectoring: each stage rotates towards y = 0 and books the angle.
	for (genvar k = 0; k < ITER; k++) begin : g_step
		logic signed [XY_W-1:0] dx, dy;
		logic signed [Z_W-1:0]  da;

		always_comb begin
			dx = y_s[k] >>> k;
			dy = x_s[k] >>> k;
			da = atan_entry(k);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[k][XY_W-1]) begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + da;
				end else begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - da;
				end
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	assign out_valid = v_s[ITER];
	assign out_z     = z_s[ITER];
	assign out_zero  = zero_s[ITER];

endmodule

/* hw/rtl/tzc_classify.sv */
module tzc_classify import tzc_pkg::*; #(
	parameter int AFB = ANGLE_FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [Z_W-1:0]    pitch_z,
	input  logic                     pitch_zero,
	input  logic signed [Z_W-1:0]    roll_z,
	input  logic                     roll_zero,
	input  thr_t                     thr,
	output logic                     out_valid,
	output logic signed [ANGLE_W-1:0] pitch_angle,
	output logic signed [ANGLE_W-1:0] roll_angle,
	output zone_t                    pitch_zone,
	output zone_t                    roll_zone
);

	localparam int CMP_W = 9 + AFB;
	localparam logic signed [Z_W-1:0] RND = Z_W'(1) <<< (ACC_FRAC - 1 - AFB);
	localparam logic signed [Z_W-1:0] LIM = Z_W'(90) <<< AFB;

	logic                     v_s1, v_s2;
	logic signed [CMP_W-1:0]  pa_s1, ra_s1;
	logic signed [ANGLE_W-1:0] pa_s2, ra_s2;
	zone_t                    pz_s2, rz_s2;
	logic signed [Z_W-1:0]    pr, rr, ps, rs;
	logic signed [CMP_W-1:0]  pu, pd, ru, rl;
	zone_t                    pz, rz;

	// Round half up to the output fraction and clamp to +-90 degrees.
	always_comb begin
		pr = (pitch_z + RND) >>> (ACC_FRAC - AFB);
		rr = (roll_z + RND) >>> (ACC_FRAC - AFB);
		ps = (pr > LIM) ? LIM : ((pr < -LIM) ? -LIM : pr);
		rs = (rr > LIM) ? LIM : ((rr < -LIM) ? -LIM : rr);
		if (pitch_zero) begin
			ps = '0;
		end
		if (roll_zero) begin
			rs = '0;
		end
	end

	// Zones; the upper test wins when the thresholds overlap.
	always_comb begin
		pu = CMP_W'(thr.pitch_up) <<< AFB;
		pd = CMP_W'(thr.pitch_down) <<< AFB;
		ru = CMP_W'(thr.roll_right) <<< AFB;
		rl = CMP_W'(thr.roll_left) <<< AFB;
		if (pa_s1 >= pu) begin
			pz = ZONE_HIGH;
		end else if (pa_s1 <= pd) begin
			pz = ZONE_LOW;
		end else begin
			pz = ZONE_LEVEL;
		end
		if (ra_s1 >= ru) begin
			rz = ZONE_HIGH;
		end else if (ra_s1 <= rl) begin
			rz = ZONE_LOW;
		end else begin
			rz = ZONE_LEVEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= CMP_W'(ps);
			ra_s1 <= CMP_W'(rs);
			pa_s2 <= ANGLE_W'(pa_s1);
			ra_s2 <= ANGLE_W'(ra_s1);
			pz_s2 <= pz;
			rz_s2 <= rz;
		end
	end

	assign out_valid   = v_s2;
	assign pitch_angle = pa_s2;
	assign roll_angle  = ra_s2;
	assign pitch_zone  = pz_s2;
	assign roll_zone   = rz_s2;

endmodule

/* hw/rtl/tilt_zone_classifier.sv */
// Channel  Handshake               Words
// in       in_valid / in_ready     accel_x, accel_y, accel_z
// out      out_valid / out_ready   pitch_angle, roll_angle, pitch_zone, roll_zone
// cfg      cfg_write (no wait)     cfg_index, cfg_data
//
// One sample enters per cycle while in_ready is high; the stages are squares,
// a bit-per-stage square root, one CORDIC stage per iteration, round and zone.
// Reset clears the valid bits and loads the default thresholds.
// The whole pipeline holds while a result waits at the output, so no word is lost.
module tilt_zone_classifier import tzc_pkg::*; #(
	parameter int CORDIC_ITERATIONS   = CORDIC_ITERATIONS_DEF,
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [ACCEL_W-1:0]  accel_x,
	input  logic signed [ACCEL_W-1:0]  accel_y,
	input  logic signed [ACCEL_W-1:0]  accel_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ANGLE_W-1:0]  pitch_angle,
	output logic signed [ANGLE_W-1:0]  roll_angle,
	output logic [1:0]                 pitch_zone,
	output logic [1:0]                 roll_zone,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	logic                      en;
	thr_t                      thr_q;
	logic                      sq_valid, sq_zero;
	logic [SUM_W-1:0]          psum, rsum;
	logic signed [ACCEL_W-1:0] pnum, rnum, pnum_r, rnum_r;
	logic                      p_rv, r_rv, p_rz, r_rz;
	logic [ROOT_W-1:0]         proot, rroot;
	logic                      p_cv, r_cv, p_cz, r_cz;
	logic signed [Z_W-1:0]     pz, rz;
	zone_t                     pzone, rzone;

	// The pipeline moves whenever the output register is free.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.pitch_up   <= 8'sd15;
			thr_q.pitch_down <= -8'sd2;
			thr_q.roll_right <= 8'sd8;
			thr_q.roll_left  <= -8'sd15;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_PITCH_UP:   thr_q.pitch_up   <= cfg_data;
				REG_PITCH_DOWN: thr_q.pitch_down <= cfg_data;
				REG_ROLL_RIGHT: thr_q.roll_right <= cfg_data;
				REG_ROLL_LEFT:  thr_q.roll_left  <= cfg_data;
				default: ;
			endcase
		end
	end

	tzc_square u_square (
		.clk, .arst_n, .en,
		.in_valid, .ax(accel_x), .ay(accel_y), .az(accel_z),
		.out_valid(sq_valid), .pitch_sum(psum), .roll_sum(rsum),
		.pitch_num(pnum), .roll_num(rnum), .zero(sq_zero)
	);

	tzc_isqrt u_isqrt_pitch (
		.clk, .arst_n, .en,
		.in_valid(sq_valid), .in_sum(psum), .in_num(pnum), .in_zero(sq_zero),
		.out_valid(p_rv), .out_root(proot), .out_num(pnum_r), .out_zero(p_rz)
	);

	tzc_isqrt u_isqrt_roll (
		.clk, .arst_n, .en,
		.in_valid(sq_valid), .in_sum(rsum), .in_num(rnum), .in_zero(sq_zero),
		.out_valid(r_rv), .out_root(rroot), .out_num(rnum_r), .out_zero(r_rz)
	);

	tzc_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pitch (
		.clk, .arst_n, .en,
		.in_valid(p_rv), .in_root(proot), .in_num(pnum_r), .in_zero(p_rz),
		.out_valid(p_cv), .out_z(pz), .out_zero(p_cz)
	);

	tzc_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_roll (
		.clk, .arst_n, .en,
		.in_valid(r_rv), .in_root(rroot), .in_num(rnum_r), .in_zero(r_rz),
		.out_valid(r_cv), .out_z(rz), .out_zero(r_cz)
	);

	tzc_classify #(.AFB(ANGLE_FRACTION_BITS)) u_classify (
		.clk, .arst_n, .en,
		.in_valid(p_cv), .pitch_z(pz), .pitch_zero(p_cz),
		.roll_z(rz), .roll_zero(r_cz), .thr(thr_q),
		.out_valid, .pitch_angle, .roll_angle,
		.pitch_zone(pzone), .roll_zone(rzone)
	);

	assign pitch_zone = pzone;
	assign roll_zone  = rzone;

	// The pitch and roll lanes must stay in lock step.
	a_root_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		p_rv == r_rv) else $error("square root lanes out of step");

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		p_cv == r_cv) else $error("CORDIC lanes out of step");

	a_zero_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		p_cv |-> (p_cz == r_cz)) else $error("zero flags differ between lanes");

	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_zone != 2'd3 && roll_zone != 2'd3))
		else $error("invalid zone code");

endmodule
